FILE: sv/atpa_pkg.sv
// Shared types, widths and constants of the four-quadrant arctangent block.
`default_nettype none
package atpa_pkg;

    localparam int INPUT_WIDTH     = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ANGLE_W         = ANGLE_FRAC_BITS + 3;
    localparam int FRAC_W          = 16;
    localparam int MAG_W           = INPUT_WIDTH;
    localparam int Q_W             = FRAC_W + 1;
    localparam int P_W             = FRAC_W + 2;
    localparam int V_W             = P_W + 1;
    localparam int HORNER_STEPS    = 5;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic signed [P_W-1:0] P_INIT = P_W'(-883);
    localparam logic signed [P_W-1:0] HORNER_C [HORNER_STEPS] = '{
        P_W'(3767), P_W'(-7946), P_W'(12821), P_W'(-21823), P_W'(65536)
    };
    localparam logic signed [V_W-1:0] HALF_PI_Q16 = V_W'(102944);
    localparam logic signed [V_W-1:0] PI_Q16      = V_W'(205887);
    localparam int ANGLE_LIMIT = 25736;

    typedef struct packed {
        logic signed [INPUT_WIDTH-1:0] x_coord;
        logic signed [INPUT_WIDTH-1:0] y_coord;
    } atpa_in_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic                      both_zero;
    } atpa_out_t;

    typedef struct packed {
        logic swap;
        logic x_neg;
        logic y_neg;
        logic zero;
    } atpa_flags_t;

    typedef struct packed {
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] mn;
        atpa_flags_t      flags;
    } atpa_job_t;

endpackage
`default_nettype wire

FILE: sv/atpa_front.sv
// Front stage: takes a point, forms magnitudes and classifies its octant.
`default_nettype none
module atpa_front
    import atpa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      sample_valid,
    output logic           sample_stall,
    input  wire atpa_in_t  sample,
    input  wire logic      fifo_full,
    output logic           job_valid,
    output atpa_job_t      job
);

    logic             job_valid_reg;
    atpa_job_t        job_reg;
    atpa_job_t        job_next;
    logic             advance;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;

    assign advance      = !job_valid_reg || !fifo_full;
    assign sample_stall = !advance;

    always_comb
    begin
        ax = sample.x_coord[INPUT_WIDTH-1] ? MAG_W'(~sample.x_coord + 1'b1)
                                           : MAG_W'(sample.x_coord);
        ay = sample.y_coord[INPUT_WIDTH-1] ? MAG_W'(~sample.y_coord + 1'b1)
                                           : MAG_W'(sample.y_coord);
        job_next.flags.swap  = ay > ax;
        job_next.flags.x_neg = sample.x_coord[INPUT_WIDTH-1];
        job_next.flags.y_neg = sample.y_coord[INPUT_WIDTH-1];
        job_next.mx          = (ay > ax) ? ay : ax;
        job_next.mn          = (ay > ax) ? ax : ay;
        job_next.flags.zero  = (ax == '0) && (ay == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            job_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule
`default_nettype wire

FILE: sv/atpa_fifo.sv
// Short queue that decouples the front stage from the arithmetic pipeline.
`default_nettype none
module atpa_fifo
    import atpa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire atpa_job_t push_data,
    input  wire logic      pop,
    output atpa_job_t      head,
    output logic           full,
    output logic           empty
);

    atpa_job_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg;
    logic                  push_ok;
    logic                  pop_ok;

    assign full    = count_reg == (FIFO_PTR_W + 1)'(FIFO_DEPTH);
    assign empty   = count_reg == '0;
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_ok && !pop_ok)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_ok && !push_ok)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_PTR_W + 1)'(FIFO_DEPTH))
        else $error("Queue count exceeds its depth.");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (push_ok && pop_ok) |=> $stable(count_reg))
        else $error("Simultaneous transfer in and out changed the count.");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_PTR_W-1:0])
        else $error("Queue pointers disagree with the count.");

endmodule
`default_nettype wire

FILE: sv/atpa_div.sv
// Pipelined restoring divider that forms the rounded Q1.16 ratio min / max.
`default_nettype none
module atpa_div
    import atpa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic         in_valid,
    input  wire [MAG_W-1:0]   mx,
    input  wire [MAG_W-1:0]   mn,
    input  wire atpa_flags_t  in_flags,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output atpa_flags_t       out_flags
);

    localparam int NW = MAG_W + FRAC_W;

    logic [NW-1:0] num;
    logic          v_reg   [0:Q_W];
    logic [MAG_W-1:0] rem_reg [0:Q_W];
    logic [MAG_W-1:0] mx_reg  [0:Q_W];
    logic [Q_W-1:0]   low_reg [0:Q_W];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    atpa_flags_t      flg_reg [0:Q_W];

    assign num = {mn, FRAC_W'(0)} + NW'(mx >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= MAG_W'(num[NW-1:Q_W]);
            low_reg[0] <= num[Q_W-1:0];
            q_reg[0]   <= '0;
            mx_reg[0]  <= mx;
            flg_reg[0] <= in_flags;
        end
    end

    for (genvar i = 0; i < Q_W; i++)
    begin : g_step
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        logic           ge;

        assign trial = {rem_reg[i], low_reg[i][Q_W-1]};
        assign ge    = trial >= {1'b0, mx_reg[i]};
        assign diff  = trial - {1'b0, mx_reg[i]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                low_reg[i+1] <= {low_reg[i][Q_W-2:0], 1'b0};
                q_reg[i+1]   <= {q_reg[i][Q_W-2:0], ge};
                mx_reg[i+1]  <= mx_reg[i];
                flg_reg[i+1] <= flg_reg[i];
            end
        end
    end

    assign out_valid = v_reg[Q_W];
    assign quo       = q_reg[Q_W];
    assign out_flags = flg_reg[Q_W];

endmodule
`default_nettype wire

FILE: sv/atpa_back.sv
// Back pipeline: ratio, Horner polynomial, octant fold and output register.
`default_nettype none
module atpa_back
    import atpa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fifo_empty,
    input  wire atpa_job_t head,
    output logic           pop,
    output logic           result_valid,
    input  wire logic      result_stall,
    output atpa_out_t      result
);

    localparam logic signed [P_W+Q_W:0] RND = (P_W + Q_W + 1)'(32768);

    logic             en;
    logic             dv;
    logic [Q_W-1:0]   dq;
    atpa_flags_t      dflags;

    logic                  hv_reg [0:HORNER_STEPS];
    logic signed [P_W-1:0] hp_reg [0:HORNER_STEPS];
    logic [Q_W-1:0]        hr_reg [0:HORNER_STEPS];
    logic [Q_W-1:0]        hs_reg [0:HORNER_STEPS];
    atpa_flags_t           hf_reg [0:HORNER_STEPS];

    logic [2*Q_W-1:0]      sq;
    logic                  tv_reg;
    logic [P_W-1:0]        t_reg;
    atpa_flags_t           tf_reg;
    logic signed [P_W+Q_W:0] tprod;
    logic signed [P_W+Q_W:0] tround;

    logic                  out_valid_reg;
    atpa_out_t             out_reg;
    atpa_out_t             out_next;
    logic signed [V_W-1:0] v0;
    logic signed [V_W-1:0] v1;
    logic signed [V_W-1:0] v2;
    logic [V_W-1:0]        vu;
    logic [ANGLE_W-1:0]    mag;

    assign en  = !out_valid_reg || !result_stall;
    assign pop = en && !fifo_empty;

    atpa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (!fifo_empty),
        .mx        (head.mx),
        .mn        (head.mn),
        .in_flags  (head.flags),
        .out_valid (dv),
        .quo       (dq),
        .out_flags (dflags)
    );

    assign sq = (dq * dq) + (2 * Q_W)'(32768);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            hv_reg[0] <= dv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hp_reg[0] <= P_INIT;
            hr_reg[0] <= dq;
            hs_reg[0] <= sq[FRAC_W+Q_W-1:FRAC_W];
            hf_reg[0] <= dflags;
        end
    end

    for (genvar h = 0; h < HORNER_STEPS; h++)
    begin : g_horner
        logic signed [P_W+Q_W:0] prod;
        logic signed [P_W+Q_W:0] rnd;
        logic signed [P_W-1:0]   p_next;

        assign prod   = hp_reg[h] * $signed({1'b0, hs_reg[h]});
        assign rnd    = prod + RND;
        assign p_next = P_W'(rnd >>> FRAC_W) + HORNER_C[h];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hv_reg[h+1] <= 1'b0;
            end
            else if (en)
            begin
                hv_reg[h+1] <= hv_reg[h];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hp_reg[h+1] <= p_next;
                hr_reg[h+1] <= hr_reg[h];
                hs_reg[h+1] <= hs_reg[h];
                hf_reg[h+1] <= hf_reg[h];
            end
        end
    end

    assign tprod  = hp_reg[HORNER_STEPS] * $signed({1'b0, hr_reg[HORNER_STEPS]});
    assign tround = (tprod + RND) >>> FRAC_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg <= 1'b0;
        end
        else if (en)
        begin
            tv_reg <= hv_reg[HORNER_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg  <= tround[P_W+Q_W] ? '0 : tround[P_W-1:0];
            tf_reg <= hf_reg[HORNER_STEPS];
        end
    end

    always_comb
    begin
        v0 = $signed({1'b0, t_reg});
        v1 = tf_reg.swap  ? (HALF_PI_Q16 - v0) : v0;
        v2 = tf_reg.x_neg ? (PI_Q16 - v1) : v1;
        vu = v2[V_W-1] ? '0 : v2;
    end

    if (ANGLE_FRAC_BITS < FRAC_W)
    begin : g_round
        localparam int SH = FRAC_W - ANGLE_FRAC_BITS;
        logic [V_W-1:0] rsum;
        assign rsum = vu + V_W'(1 << (SH - 1));
        assign mag  = ANGLE_W'(rsum >> SH);
    end
    else if (ANGLE_FRAC_BITS == FRAC_W)
    begin : g_same
        assign mag = ANGLE_W'(vu);
    end
    else
    begin : g_widen
        localparam int SH = ANGLE_FRAC_BITS - FRAC_W;
        assign mag = ANGLE_W'(vu) << SH;
    end

    always_comb
    begin
        out_next.both_zero = tf_reg.zero;
        if (tf_reg.zero)
        begin
            out_next.angle = '0;
        end
        else if (tf_reg.y_neg)
        begin
            out_next.angle = $signed(ANGLE_W'(0) - mag);
        end
        else
        begin
            out_next.angle = $signed(mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= tv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.both_zero) |-> (result.angle == '0))
        else $error("Zero point produced a nonzero angle.");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.angle >= -ANGLE_LIMIT) && (result.angle <= ANGLE_LIMIT)))
        else $error("Angle outside minus pi to pi.");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(tv_reg) && $stable(hv_reg[HORNER_STEPS])))
        else $error("Pipeline moved while the result was stalled.");

endmodule
`default_nettype wire

FILE: sv/atpa2_top_placeholder.sv
// Combined output check for the arctangent pipeline ports.
`default_nettype none
module atpa_port_check
    import atpa_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      result_valid,
    input wire logic      result_stall,
    input wire atpa_out_t result
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("Result valid dropped while stalled.");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(result))
        else $error("Stalled result changed.");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.both_zero) |-> (result.angle == '0))
        else $error("Zero flag with nonzero angle at the port.");

    a_pos_pi: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.both_zero && result.angle[ANGLE_W-1])
            |-> (result.angle != '0))
        else $error("Negative angle reads as zero.");

endmodule
`default_nettype wire

FILE: sv/atan2_polynomial_approx.sv
// Top level of the four-quadrant fixed-point arctangent block.
// The block takes one point per clock while sample_stall is low and returns
// its angle in Q3.13 radians through one front register, the queue memory,
// eighteen divider stages, the square, five Horner stages, the final product
// and the output register. The pipelined divider and the Horner multipliers
// set the depth of that pipeline, and a four-entry queue lets the front keep
// taking points while the output is stalled, until the queue fills. A point
// with both components zero gives angle zero with both_zero set.
`default_nettype none
module atan2_polynomial_approx
    import atpa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     sample_valid,
    output logic          sample_stall,
    input  wire atpa_in_t sample,
    output logic          result_valid,
    input  wire logic     result_stall,
    output atpa_out_t     result
);

    logic      job_valid;
    atpa_job_t job;
    logic      fifo_full;
    logic      fifo_empty;
    logic      pop;
    atpa_job_t head;

    atpa_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .fifo_full    (fifo_full),
        .job_valid    (job_valid),
        .job          (job)
    );

    atpa_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_valid),
        .push_data (job),
        .pop       (pop),
        .head      (head),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    atpa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fifo_empty   (fifo_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    atpa_port_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire
